// ===== src/slab_object_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Slab object allocator assertion macros
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SOA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slab allocator check failed");

// next-cycle implication
`define SOA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slab allocator check failed");

`endif

// ===== src/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared constants, codes and transfer payload types.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int DEF_SLAB_BYTES       = 16384;
  localparam int DEF_MAX_SLABS        = 16;
  localparam int DEF_MIN_OBJECT_BYTES = 8;

  localparam int ADDR_W      = 18;
  localparam int OBJ_BYTES_W = 15;
  localparam int STATUS_W    = 3;
  localparam int SLABS_W     = 5;

  localparam logic [OBJ_BYTES_W-1:0] OBJ_BYTES_RESET = 15'd64;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOC      = 3'd0,
    STATUS_FAIL       = 3'd1,
    STATUS_FREED      = 3'd2,
    STATUS_IGNORED    = 3'd3,
    STATUS_MISALIGNED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC,
    ST_LINK,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  object_address;
    logic [SLABS_W-1:0] slabs_in_use;
  } rsp_t;

endpackage

// ===== src/soa_divider.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module soa_divider #(
  parameter int DIVIDEND_W = 15,
  parameter int DIVISOR_W  = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W:0]   rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic                 take;

  assign shifted   = {rem[DIVISOR_W-1:0], quotient[DIVIDEND_W-1]};
  assign take      = shifted >= {1'b0, dvs};
  assign remainder = rem[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], take};
      rem      <= take ? shifted - {1'b0, dvs} : shifted;
    end
  end

endmodule

// ===== src/soa_slab_store.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator slab store
// Per-slab record memory with a flag vector of slabs that can allocate.
// ----------------------------------------------------------------------------
module soa_slab_store #(
  parameter int MAX_SLABS = 16,
  parameter int SIDX_W    = 4,
  parameter int CNT_W     = 12,
  parameter int IDX_W     = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SIDX_W-1:0] rd_addr,
  output logic [CNT_W-1:0]  rd_free,
  output logic [CNT_W-1:0]  rd_untouched,
  output logic [IDX_W-1:0]  rd_head,
  output logic              rd_head_valid,
  input  logic              wr_en,
  input  logic [SIDX_W-1:0] wr_addr,
  input  logic [CNT_W-1:0]  wr_free,
  input  logic [CNT_W-1:0]  wr_untouched,
  input  logic [IDX_W-1:0]  wr_head,
  input  logic              wr_head_valid,
  output logic              any_avail,
  output logic [SIDX_W-1:0] first_avail
);

  localparam int REC_W = 2 * CNT_W + IDX_W + 1;

  logic [REC_W-1:0]     mem [MAX_SLABS];
  logic [REC_W-1:0]     rd_q;
  logic [MAX_SLABS-1:0] avail;

  assign {rd_free, rd_untouched, rd_head, rd_head_valid} = rd_q;
  assign any_avail = |avail;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_free, wr_untouched, wr_head, wr_head_valid};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
    end else if (wr_en) begin
      avail[wr_addr] <= (wr_free != '0) && (wr_head_valid || (wr_untouched != '0));
    end
  end

  always_comb begin
    first_avail = '0;
    for (int i = MAX_SLABS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        first_avail = SIDX_W'(i);
      end
    end
  end

endmodule

// ===== src/soa_link_store.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator link store
// Freed-object stack links, one read and one write port.
// ----------------------------------------------------------------------------
module soa_link_store #(
  parameter int ADDR_BITS = 15,
  parameter int DATA_W    = 12
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_W-1:0]    rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_W-1:0]    wr_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator
// Sequence: accept, bit-serial divide, execute, a link read when a freed object
// is popped, multiply for an allocated address, then hand off the result.
// A new request is taken only after the previous result is loaded for output.
// Reset: synchronous; clears grown slabs and free flags, object size to 64.
// ----------------------------------------------------------------------------
`include "slab_object_allocator_assert.svh"

module slab_object_allocator #(
  parameter int SLAB_BYTES       = soa_pkg::DEF_SLAB_BYTES,
  parameter int MAX_SLABS        = soa_pkg::DEF_MAX_SLABS,
  parameter int MIN_OBJECT_BYTES = soa_pkg::DEF_MIN_OBJECT_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  soa_pkg::req_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output soa_pkg::rsp_t                    out_data,
  input  logic                             cfg_wr_en,
  input  logic [soa_pkg::OBJ_BYTES_W-1:0]  cfg_wr_data
);

  import soa_pkg::*;

  localparam int SLAB_W  = $clog2(SLAB_BYTES);
  localparam int DIV_W   = SLAB_W + 1;
  localparam int OBJ_MAX = SLAB_BYTES / MIN_OBJECT_BYTES;
  localparam int IDX_W   = $clog2(OBJ_MAX);
  localparam int CNT_W   = $clog2(OBJ_MAX + 1);
  localparam int SIDX_W  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int GW      = $clog2(MAX_SLABS + 1);
  localparam int SN_W    = ADDR_W - SLAB_W;
  localparam int CMP_W   = (SN_W > GW) ? SN_W : GW;
  localparam int SUM_W   = ((SLAB_W > OBJ_BYTES_W) ? SLAB_W : OBJ_BYTES_W) + 1;
  localparam int PROD_W  = IDX_W + OBJ_BYTES_W;
  localparam int LINK_AW = SIDX_W + IDX_W;

  state_t                 state, state_next;
  op_t                    op;
  logic [ADDR_W-1:0]      addr;
  logic                   found;
  logic [SIDX_W-1:0]      slab;
  logic [GW-1:0]          grown;
  logic [OBJ_BYTES_W-1:0] obj_bytes;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [ADDR_W-1:0]      prod;
  status_t                status, status_next;

  logic                   accept;
  logic [OBJ_BYTES_W-1:0] size;
  logic [SN_W-1:0]        in_slab, a_slab;
  logic [SLAB_W-1:0]      in_off, a_off;
  logic                   div_start, div_busy;
  logic [DIV_W-1:0]       div_dividend, quo;
  logic [OBJ_BYTES_W-1:0] rem;
  logic [SIDX_W-1:0]      rd_addr;
  logic [CNT_W-1:0]       rd_free, rd_untouched;
  logic [IDX_W-1:0]       rd_head;
  logic                   rd_hv;
  logic                   rec_wr_en;
  logic [SIDX_W-1:0]      rec_wr_addr;
  logic [CNT_W-1:0]       rec_wr_free, rec_wr_untouched;
  logic [IDX_W-1:0]       rec_wr_head;
  logic                   rec_wr_hv;
  logic                   any_avail;
  logic [SIDX_W-1:0]      first_avail;
  logic                   link_rd_en, link_wr_en;
  logic [LINK_AW-1:0]     link_rd_addr, link_wr_addr;
  logic [CNT_W-1:0]       link_rd_data, link_wr_data;
  logic [CNT_W-1:0]       cap;
  logic                   grow;
  logic                   out_load;
  logic [PROD_W-1:0]      prod_full;
  logic [ADDR_W-1:0]      obj_addr;

  assign accept  = in_valid && in_ready;
  assign size    = (obj_bytes < OBJ_BYTES_W'(MIN_OBJECT_BYTES)) ?
                   OBJ_BYTES_W'(MIN_OBJECT_BYTES) : obj_bytes;
  assign in_slab = in_data.free_address[ADDR_W-1:SLAB_W];
  assign in_off  = in_data.free_address[SLAB_W-1:0];
  assign a_slab  = addr[ADDR_W-1:SLAB_W];
  assign a_off   = addr[SLAB_W-1:0];
  assign cap     = CNT_W'(quo);

  assign div_dividend = (in_data.op == OP_FREE) ? {1'b0, in_off} : DIV_W'(SLAB_BYTES);
  assign rd_addr      = (in_data.op == OP_FREE) ? SIDX_W'(in_slab) : first_avail;
  assign link_rd_addr = {slab, rd_head};
  assign link_wr_addr = {slab, IDX_W'(quo)};
  assign prod_full    = PROD_W'(idx) * PROD_W'(size);
  assign obj_addr     = (status == STATUS_ALLOC) ?
                        ADDR_W'({slab, {SLAB_W{1'b0}}}) + prod : '0;

  soa_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (OBJ_BYTES_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (size),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  soa_slab_store #(
    .MAX_SLABS (MAX_SLABS),
    .SIDX_W    (SIDX_W),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_slab (
    .clk           (clk),
    .rst           (rst),
    .rd_en         (accept),
    .rd_addr       (rd_addr),
    .rd_free       (rd_free),
    .rd_untouched  (rd_untouched),
    .rd_head       (rd_head),
    .rd_head_valid (rd_hv),
    .wr_en         (rec_wr_en),
    .wr_addr       (rec_wr_addr),
    .wr_free       (rec_wr_free),
    .wr_untouched  (rec_wr_untouched),
    .wr_head       (rec_wr_head),
    .wr_head_valid (rec_wr_hv),
    .any_avail     (any_avail),
    .first_avail   (first_avail)
  );

  soa_link_store #(
    .ADDR_BITS (LINK_AW),
    .DATA_W    (CNT_W)
  ) u_link (
    .clk     (clk),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    div_start        = 1'b0;
    rec_wr_en        = 1'b0;
    rec_wr_addr      = slab;
    rec_wr_free      = rd_free;
    rec_wr_untouched = rd_untouched;
    rec_wr_head      = rd_head;
    rec_wr_hv        = rd_hv;
    link_rd_en       = 1'b0;
    link_wr_en       = 1'b0;
    link_wr_data     = '0;
    grow             = 1'b0;
    idx_next         = idx;
    status_next      = status;
    out_load         = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op == OP_ALLOC) begin
          if (found && rd_hv) begin
            link_rd_en = 1'b1;
            state_next = ST_LINK;
          end else if (found) begin
            rec_wr_en        = 1'b1;
            rec_wr_free      = rd_free - 1'b1;
            rec_wr_untouched = rd_untouched - 1'b1;
            idx_next         = IDX_W'(rd_untouched - 1'b1);
            status_next      = STATUS_ALLOC;
            state_next       = ST_MUL;
          end else if (grown < GW'(MAX_SLABS) && quo != '0) begin
            grow             = 1'b1;
            rec_wr_en        = 1'b1;
            rec_wr_addr      = SIDX_W'(grown);
            rec_wr_free      = cap - 1'b1;
            rec_wr_untouched = cap - 1'b1;
            rec_wr_head      = '0;
            rec_wr_hv        = 1'b0;
            idx_next         = IDX_W'(cap - 1'b1);
            status_next      = STATUS_ALLOC;
            state_next       = ST_MUL;
          end else begin
            status_next = STATUS_FAIL;
            state_next  = ST_DONE;
          end
        end else begin
          state_next = ST_DONE;
          if (CMP_W'(a_slab) >= CMP_W'(grown)) begin
            status_next = STATUS_IGNORED;
          end else if (rem != '0 ||
                       SUM_W'(a_off) + SUM_W'(size) > SUM_W'(SLAB_BYTES)) begin
            status_next = STATUS_MISALIGNED;
          end else begin
            link_wr_en   = 1'b1;
            link_wr_data = rd_hv ? CNT_W'(rd_head) + 1'b1 : '0;
            rec_wr_en    = 1'b1;
            rec_wr_head  = IDX_W'(quo);
            rec_wr_hv    = 1'b1;
            rec_wr_free  = (rd_free < CNT_W'(OBJ_MAX)) ? rd_free + 1'b1 : rd_free;
            status_next  = STATUS_FREED;
          end
        end
      end
      ST_LINK: begin
        rec_wr_en   = 1'b1;
        rec_wr_free = rd_free - 1'b1;
        if (link_rd_data != '0) begin
          rec_wr_head = IDX_W'(link_rd_data - 1'b1);
          rec_wr_hv   = 1'b1;
        end else begin
          rec_wr_hv = 1'b0;
        end
        idx_next    = rd_head;
        status_next = STATUS_ALLOC;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grown     <= '0;
      obj_bytes <= OBJ_BYTES_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en && grown == '0) begin
        obj_bytes <= cfg_wr_data;
      end
      if (grow) begin
        grown <= grown + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_data.op;
      addr  <= in_data.free_address;
      slab  <= rd_addr;
      found <= any_avail;
    end
    if (grow) begin
      slab <= SIDX_W'(grown);
    end
    idx    <= idx_next;
    status <= status_next;
    if (state == ST_MUL) begin
      prod <= ADDR_W'(prod_full);
    end
    if (out_load) begin
      out_data.status         <= status;
      out_data.object_address <= obj_addr;
      out_data.slabs_in_use   <= SLABS_W'(grown);
    end
  end

  `SOA_ASSERT_NOW(a_grown_bound, 1'b1, grown <= GW'(MAX_SLABS))
  `SOA_ASSERT_NOW(a_grow_step, grown != $past(grown), grown == $past(grown) + 1'b1)
  `SOA_ASSERT_NOW(a_size_frozen, grown != '0, $stable(obj_bytes))
  `SOA_ASSERT_NOW(a_result_source, $rose(out_valid), $past(state) == ST_DONE)
  `SOA_ASSERT_NEXT(a_accept_idle, accept, !in_ready && !out_load)

endmodule

// ===== tb/sv/slab_object_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator testbench
// Drives allocate and free requests over valid/ready and checks every result
// against a cycle-free predictor of the slab state. A directed table covers
// reset behavior, oversize objects, tail slack, misaligned and outside frees,
// double frees and size writes after growth; three random phases with
// different traffic mixes and idling then fill, drain and churn the slabs.
// ----------------------------------------------------------------------------
module slab_object_allocator_tb;
  import soa_pkg::*;

  localparam int SLAB_BYTES   = DEF_SLAB_BYTES;
  localparam int MAX_SLABS    = DEF_MAX_SLABS;
  localparam int MIN_OBJ      = DEF_MIN_OBJECT_BYTES;
  localparam int OBJ_MAX      = SLAB_BYTES / MIN_OBJ;
  localparam int ADDR_MAX     = (1 << ADDR_W) - 1;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int N_ROWS       = 25;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    op_t                    op;
    logic [ADDR_W-1:0]      addr;
    logic [OBJ_BYTES_W-1:0] cfg_value;
    bit                     typed;
    status_t                want_status;
    logic [ADDR_W-1:0]      want_addr;
    logic [SLABS_W-1:0]     want_slabs;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  req_t                   in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rsp_t                   out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [OBJ_BYTES_W-1:0] cfg_wr_data = '0;

  // slab state as the block should hold it
  logic [OBJ_BYTES_W-1:0] obj_bytes_now;
  logic [SLABS_W-1:0]     slabs_grown;
  logic [11:0]            free_left [MAX_SLABS];
  logic [11:0]            fresh_left [MAX_SLABS];
  logic [11:0]            stack_head [MAX_SLABS];
  bit                     stack_nonempty [MAX_SLABS];
  logic [11:0]            stack_next [MAX_SLABS*OBJ_MAX];

  rsp_t                   pending_outcomes [$];
  logic [ADDR_W-1:0]      held_objects [$];
  int                     fail_count = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  bit                     hold_off_req = 1'b0;

  plan_row_t directed_plan [N_ROWS] = '{
    '{ROW_CFG,  OP_ALLOC, 18'd0,      15'd1,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd0,      15'd0,     1'b1, STATUS_IGNORED,    18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd262143, 15'd0,     1'b1, STATUS_IGNORED,    18'd0,     5'd0},
    '{ROW_CFG,  OP_ALLOC, 18'd0,      15'd32767, 1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd262143, 15'd0,     1'b1, STATUS_FAIL,       18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd16000,  15'd0,     1'b1, STATUS_IGNORED,    18'd0,     5'd0},
    '{ROW_CFG,  OP_ALLOC, 18'd0,      15'd2000,  1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b1, STATUS_ALLOC,      18'd14000, 5'd1},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd14000,  15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd12000,  15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd16000,  15'd0,     1'b1, STATUS_MISALIGNED, 18'd0,     5'd1},
    '{ROW_ITEM, OP_FREE,  18'd2001,   15'd0,     1'b1, STATUS_MISALIGNED, 18'd0,     5'd1},
    '{ROW_ITEM, OP_FREE,  18'd16384,  15'd0,     1'b1, STATUS_IGNORED,    18'd0,     5'd1},
    '{ROW_ITEM, OP_FREE,  18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_CFG,  OP_ALLOC, 18'd0,      15'd8,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_FREE,  18'd262143, 15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_CFG,  OP_ALLOC, 18'd0,      15'd16384, 1'b0, STATUS_ALLOC,      18'd0,     5'd0},
    '{ROW_ITEM, OP_ALLOC, 18'd0,      15'd0,     1'b0, STATUS_ALLOC,      18'd0,     5'd0}
  };

  slab_object_allocator u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned object_size();
    return (obj_bytes_now < MIN_OBJ) ? MIN_OBJ : obj_bytes_now;
  endfunction

  function automatic logic [ADDR_W-1:0] pop_object(input int unsigned s);
    int unsigned idx;
    if (stack_nonempty[s]) begin
      idx = stack_head[s] % OBJ_MAX;
      if (stack_next[s*OBJ_MAX + idx] == 0) begin
        stack_nonempty[s] = 1'b0;
      end else begin
        stack_head[s] = (stack_next[s*OBJ_MAX + idx] - 1) % OBJ_MAX;
      end
    end else begin
      fresh_left[s] = fresh_left[s] - 1;
      idx = fresh_left[s];
    end
    free_left[s] = free_left[s] - 1;
    return ADDR_W'(s * SLAB_BYTES + idx * object_size());
  endfunction

  task automatic resolve_request(input req_t r, output rsp_t o);
    int unsigned size, cap, a, s, off, idx, i;
    bit done;
    size = object_size();
    cap  = SLAB_BYTES / size;
    o = '0;
    o.status = STATUS_ALLOC;
    if (r.op == OP_ALLOC) begin
      done = 1'b0;
      for (i = 0; i < slabs_grown && !done; i++) begin
        if (free_left[i] > 0 && (stack_nonempty[i] || fresh_left[i] > 0)) begin
          o.object_address = pop_object(i);
          done = 1'b1;
        end
      end
      if (!done) begin
        if (slabs_grown < MAX_SLABS && cap > 0) begin
          s = slabs_grown;
          slabs_grown = slabs_grown + 1;
          free_left[s]      = cap;
          fresh_left[s]     = cap;
          stack_nonempty[s] = 1'b0;
          stack_head[s]     = '0;
          o.object_address  = pop_object(s);
        end else begin
          o.status = STATUS_FAIL;
        end
      end
    end else begin
      a   = r.free_address;
      s   = a / SLAB_BYTES;
      off = a % SLAB_BYTES;
      if (s >= slabs_grown || s >= MAX_SLABS) begin
        o.status = STATUS_IGNORED;
      end else if (off % size != 0 || off / size >= cap) begin
        o.status = STATUS_MISALIGNED;
      end else begin
        idx = (off / size) % OBJ_MAX;
        stack_next[s*OBJ_MAX + idx] = stack_nonempty[s] ? stack_head[s] + 1 : 0;
        stack_head[s]     = idx;
        stack_nonempty[s] = 1'b1;
        if (free_left[s] < OBJ_MAX) free_left[s] = free_left[s] + 1;
        o.status = STATUS_FREED;
      end
    end
    o.slabs_in_use = slabs_grown;
  endtask

  // hold valid and payload until the transfer
  task automatic offer_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    resolve_request(r, predicted);
    if (predicted.status == STATUS_ALLOC) held_objects.push_back(predicted.object_address);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic write_object_bytes(input logic [OBJ_BYTES_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (slabs_grown == 0) obj_bytes_now = v;
  endtask

  task automatic next_random_request(input int alloc_pct, input int free_pct,
                                     output req_t r);
    int roll, k;
    int unsigned size;
    roll = $urandom_range(99);
    r.free_address = ADDR_W'($urandom_range(ADDR_MAX));
    if (roll < alloc_pct) begin
      r.op = OP_ALLOC;
    end else if (roll < alloc_pct + free_pct) begin
      r.op = OP_FREE;
      if (held_objects.size() != 0 && $urandom_range(9) != 0) begin
        k = $urandom_range(held_objects.size() - 1);
        r.free_address = held_objects[k];
        held_objects.delete(k);
      end else if (slabs_grown != 0) begin
        size = object_size();
        r.free_address = ADDR_W'($urandom_range(slabs_grown - 1) * SLAB_BYTES
                         + $urandom_range(SLAB_BYTES / size - 1) * size);
      end
    end else begin
      r.op = op_t'($urandom_range(1));
    end
  endtask

  task automatic run_traffic(input int n, input int alloc_pct, input int free_pct);
    req_t r;
    repeat (n) begin
      next_random_request(alloc_pct, free_pct, r);
      offer_request(r, 1'b0, '0);
    end
  endtask

  initial begin : drive_out_ready
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready    <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %p", out_data);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_data.status !== want.status
            || out_data.object_address !== want.object_address
            || out_data.slabs_in_use !== want.slabs_in_use) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected status %0d addr %0d slabs %0d, got %0d %0d %0d",
                     want.status, want.object_address, want.slabs_in_use,
                     out_data.status, out_data.object_address, out_data.slabs_in_use);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    rsp_t want;
    obj_bytes_now = OBJ_BYTES_RESET;
    slabs_grown   = '0;
    for (int i = 0; i < MAX_SLABS; i++) begin
      free_left[i]      = '0;
      fresh_left[i]     = '0;
      stack_head[i]     = '0;
      stack_nonempty[i] = 1'b0;
    end
    for (int i = 0; i < MAX_SLABS*OBJ_MAX; i++) stack_next[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 27;
    recv_idle_pct = 85;
    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_CFG) begin
        write_object_bytes(directed_plan[k].cfg_value);
      end else begin
        r.op                = directed_plan[k].op;
        r.free_address      = directed_plan[k].addr;
        want.status         = directed_plan[k].want_status;
        want.object_address = directed_plan[k].want_addr;
        want.slabs_in_use   = directed_plan[k].want_slabs;
        offer_request(r, directed_plan[k].typed, want);
      end
    end

    // fill the slabs to exhaustion
    hold_off_req = 1'b1;
    run_traffic(220, 80, 12);
    write_object_bytes(15'd1);

    // drain
    send_idle_pct = 85;
    recv_idle_pct = 27;
    run_traffic(220, 25, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(190, 50, 35);
    in_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/soa_pkg.sv
src/soa_divider.sv
src/soa_slab_store.sv
src/soa_link_store.sv
src/slab_object_allocator.sv
tb/sv/slab_object_allocator_tb.sv
